// ===== rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants for the box placement checker.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned MaxBoxesDef  = 256;
  localparam int unsigned CoordBitsDef = 16;

  localparam int unsigned FieldW    = 16;  // width of every coordinate and size field
  localparam int unsigned LimitW    = 16;
  localparam int unsigned SumW      = FieldW + 2;
  localparam int unsigned ConflictW = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned InDataW   = 9 * FieldW;
  localparam int unsigned InUserW   = 1;
  localparam int unsigned OutDataW  = 16;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_WALL    = 3'd1,
    ST_ORIGIN  = 3'd2,
    ST_SIZE    = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LENGTH = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } fsm_e;

  typedef struct packed {
    logic [LimitW-1:0] len;
    logic [LimitW-1:0] wid;
    logic [LimitW-1:0] hgt;
  } limits_t;

  typedef struct packed {
    status_e               status;
    logic [ConflictW-1:0]  conflict;
    logic                  tour_ok;
  } result_t;

endpackage

// ===== rtl/bpc_ram.sv =====
// ----------------------------------------------------------------------------
// bpc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpc_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/bpc_prechk.sv =====
// ----------------------------------------------------------------------------
// bpc_prechk
// Wall, origin and size checks on one box, first failure wins.
// ----------------------------------------------------------------------------
module bpc_prechk #(
  parameter int unsigned COORD_W = 16
) (
  input  logic [2:0][COORD_W-1:0]            lo_i,
  input  logic [2:0][COORD_W-1:0]            hi_i,
  input  logic [2:0][bpc_pkg::FieldW-1:0]    sz_i,
  input  bpc_pkg::limits_t                   limits_i,
  output bpc_pkg::status_e                   status_o
);

  logic [2:0][COORD_W-1:0] ext;
  logic                    wall;
  logic                    origin;
  logic                    below;
  logic [bpc_pkg::SumW-1:0] ext_sum;
  logic [bpc_pkg::SumW-1:0] size_sum;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ext[a] = hi_i[a] - lo_i[a];
    end
    wall = (bpc_pkg::LimitW'(hi_i[0]) > limits_i.len) ||
           (bpc_pkg::LimitW'(hi_i[1]) > limits_i.wid) ||
           (bpc_pkg::LimitW'(hi_i[2]) > limits_i.hgt);
    origin = (hi_i[0] == '0) && (hi_i[1] == '0) && (hi_i[2] == '0);
    below  = (hi_i[0] < lo_i[0]) || (hi_i[1] < lo_i[1]) || (hi_i[2] < lo_i[2]);
    ext_sum  = bpc_pkg::SumW'(ext[0]) + bpc_pkg::SumW'(ext[1]) + bpc_pkg::SumW'(ext[2]);
    size_sum = bpc_pkg::SumW'(sz_i[0]) + bpc_pkg::SumW'(sz_i[1]) +
               bpc_pkg::SumW'(sz_i[2]);
    if (wall) begin
      status_o = bpc_pkg::ST_WALL;
    end else if (origin) begin
      status_o = bpc_pkg::ST_ORIGIN;
    end else if (below || (ext_sum != size_sum)) begin
      status_o = bpc_pkg::ST_SIZE;
    end else begin
      status_o = bpc_pkg::ST_OK;
    end
  end

endmodule

// ===== rtl/bpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_ctrl
// Sequencer: latches a box, runs the front checks, scans the corner store
// one entry per cycle and appends the box unless the store is full.
// ----------------------------------------------------------------------------
module bpc_ctrl #(
  parameter int unsigned MAX_BOXES = bpc_pkg::MaxBoxesDef,
  parameter int unsigned COORD_W   = bpc_pkg::CoordBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               new_tour_i,
  input  logic [2:0][COORD_W-1:0]            lo_i,
  input  logic [2:0][COORD_W-1:0]            hi_i,
  input  logic [2:0][bpc_pkg::FieldW-1:0]    sz_i,
  input  bpc_pkg::limits_t                   limits_i,
  output logic                               ram_we_o,
  output logic [$clog2(MAX_BOXES)-1:0]       ram_waddr_o,
  output logic [6*COORD_W-1:0]               ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(MAX_BOXES)-1:0]       ram_raddr_o,
  input  logic [6*COORD_W-1:0]               ram_rdata_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output bpc_pkg::result_t                   res_o
);

  localparam int unsigned AddrW = $clog2(MAX_BOXES);
  localparam int unsigned CntW  = $clog2(MAX_BOXES + 1);
  localparam int unsigned PadW  = (AddrW > bpc_pkg::ConflictW) ? AddrW : bpc_pkg::ConflictW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BOXES);

  bpc_pkg::fsm_e state_q, state_d;

  logic [2:0][COORD_W-1:0]         lo_q, lo_d, hi_q, hi_d;
  logic [2:0][bpc_pkg::FieldW-1:0] sz_q, sz_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            tour_q, tour_d;
  logic [AddrW-1:0]                ptr_q, ptr_d;
  bpc_pkg::status_e                status_q, status_d;
  logic [bpc_pkg::ConflictW-1:0]   conf_q, conf_d;

  bpc_pkg::status_e                pre_status;
  logic [2:0][COORD_W-1:0]         st_lo, st_hi;
  logic                            hit;
  logic                            full;
  logic                            last;
  logic [PadW-1:0]                 ptr_pad;

  bpc_prechk #(
    .COORD_W (COORD_W)
  ) u_prechk (
    .lo_i     (lo_q),
    .hi_i     (hi_q),
    .sz_i     (sz_q),
    .limits_i (limits_i),
    .status_o (pre_status)
  );

  assign st_lo = ram_rdata_i[3*COORD_W-1:0];
  assign st_hi = ram_rdata_i[6*COORD_W-1:3*COORD_W];

  // strict overlap on all three axes
  assign hit = (lo_q[0] < st_hi[0]) && (lo_q[1] < st_hi[1]) && (lo_q[2] < st_hi[2]) &&
               (st_lo[0] < hi_q[0]) && (st_lo[1] < hi_q[1]) && (st_lo[2] < hi_q[2]);

  assign full    = (cnt_q == CntMax);
  assign last    = ((CntW'(ptr_q) + CntW'(1)) == cnt_q);
  assign ptr_pad = PadW'(ptr_q);

  assign ram_waddr_o = cnt_q[AddrW-1:0];
  assign ram_wdata_o = {hi_q, lo_q};

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    sz_d        = sz_q;
    cnt_d       = cnt_q;
    tour_d      = tour_q;
    ptr_d       = ptr_q;
    status_d    = status_q;
    conf_d      = conf_q;
    in_ready_o  = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    ram_we_o    = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      bpc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          lo_d = lo_i;
          hi_d = hi_i;
          sz_d = sz_i;
          if (new_tour_i) begin
            cnt_d  = '0;
            tour_d = 1'b1;
          end
          state_d = bpc_pkg::S_CHECK;
        end
      end
      bpc_pkg::S_CHECK: begin
        conf_d = '0;
        if (pre_status != bpc_pkg::ST_OK) begin
          status_d = pre_status;
          state_d  = bpc_pkg::S_FINISH;
        end else if (cnt_q == '0) begin
          status_d = bpc_pkg::ST_OK;
          state_d  = bpc_pkg::S_FINISH;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = '0;
          ptr_d       = '0;
          state_d     = bpc_pkg::S_SCAN;
        end
      end
      bpc_pkg::S_SCAN: begin
        // read data belongs to entry ptr_q
        if (hit) begin
          status_d = bpc_pkg::ST_OVERLAP;
          conf_d   = ptr_pad[bpc_pkg::ConflictW-1:0];
          state_d  = bpc_pkg::S_FINISH;
        end else if (last) begin
          status_d = full ? bpc_pkg::ST_FULL : bpc_pkg::ST_OK;
          state_d  = bpc_pkg::S_FINISH;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = ptr_q + AddrW'(1);
          ptr_d       = ptr_q + AddrW'(1);
        end
      end
      bpc_pkg::S_FINISH: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          if (!full) begin
            ram_we_o = 1'b1;
            cnt_d    = cnt_q + CntW'(1);
          end
          tour_d  = tour_q & (status_q == bpc_pkg::ST_OK);
          state_d = bpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpc_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o.status   = status_q;
  assign res_o.conflict = conf_q;
  assign res_o.tour_ok  = tour_q & (status_q == bpc_pkg::ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::S_IDLE;
      cnt_q   <= '0;
      tour_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tour_q  <= tour_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    sz_q     <= sz_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    conf_q   <= conf_d;
  end

endmodule

// ===== rtl/box_placement_checker_core.sv =====
// ----------------------------------------------------------------------------
// box_placement_checker_core
// Checks each placed box against the vehicle limits, its nominal size and
// every box stored so far in the tour, and appends it to the corner store unless full.
// ----------------------------------------------------------------------------
//  channel   | direction | accepted when                  | payload
//  s_axis    | in        | s_axis_tvalid & s_axis_tready  | box corners, sizes, new_tour
//  m_axis    | out       | m_axis_tvalid & m_axis_tready  | status, conflict index, tour_ok
//  cfg       | in        | cfg_we_i                       | vehicle limit register
//
// A box runs through the front check, a scan of n stored boxes and the
// finish state before its result sits in the output register (n at most
// MAX_BOXES, less on an early overlap hit or a failed front check, where
// n is 0). The scan is set by the corner RAM's single read port, one entry
// per cycle. The next box is accepted the cycle after the result is
// registered, while that result still waits on m_axis. Reset empties the
// store at once through the box count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module box_placement_checker_core #(
  parameter int unsigned MAX_BOXES  = bpc_pkg::MaxBoxesDef,
  parameter int unsigned COORD_BITS = bpc_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, size_len, size_wid, size_hgt
  input  logic [bpc_pkg::InDataW-1:0]   s_axis_tdata,
  // new_tour
  input  logic [bpc_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status[2:0], conflict_index[10:3], tour_ok[11], zero fill
  output logic [bpc_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [bpc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bpc_pkg::LimitW-1:0]    cfg_data_i
);

  localparam int unsigned CoordW = (COORD_BITS < bpc_pkg::FieldW) ? COORD_BITS
                                                                  : bpc_pkg::FieldW;
  localparam int unsigned AddrW  = $clog2(MAX_BOXES);
  localparam int unsigned FW     = bpc_pkg::FieldW;

  bpc_pkg::limits_t limits_q;

  logic [2:0][CoordW-1:0] in_lo, in_hi;
  logic [2:0][FW-1:0]     in_sz;

  logic                   ram_we, ram_re;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  logic [6*CoordW-1:0]    ram_wdata, ram_rdata;

  logic                   res_valid, res_ready;
  bpc_pkg::result_t       res;

  logic                   out_valid_q;
  bpc_pkg::result_t       out_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_lo[a] = s_axis_tdata[a*FW +: CoordW];
      in_hi[a] = s_axis_tdata[(a+3)*FW +: CoordW];
      in_sz[a] = s_axis_tdata[(a+6)*FW +: FW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '1;
    end else if (cfg_we_i) begin
      case (bpc_pkg::cfg_reg_e'(cfg_idx_i))
        bpc_pkg::REG_LENGTH: limits_q.len <= cfg_data_i;
        bpc_pkg::REG_WIDTH:  limits_q.wid <= cfg_data_i;
        bpc_pkg::REG_HEIGHT: limits_q.hgt <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpc_ctrl #(
    .MAX_BOXES (MAX_BOXES),
    .COORD_W   (CoordW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .new_tour_i  (s_axis_tuser[0]),
    .lo_i        (in_lo),
    .hi_i        (in_hi),
    .sz_i        (in_sz),
    .limits_i    (limits_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  bpc_ram #(
    .WIDTH (6 * CoordW),
    .DEPTH (MAX_BOXES)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: frees the sequencer while a result waits
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q.tour_ok, out_q.conflict, out_q.status};

endmodule

// ===== rtl/bpc_checker.sv =====
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level assertions for the box placement checker, bound to the top.
// ----------------------------------------------------------------------------
module bpc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bpc_pkg::OutDataW-1:0]  m_axis_tdata
);

  logic [2:0] st;
  assign st = m_axis_tdata[2:0];

  // one box in flight: no transaction directly after an accepted one
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st <= bpc_pkg::ST_FULL))
    else $error("status code out of range");

  a_conflict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st != bpc_pkg::ST_OVERLAP) |-> (m_axis_tdata[10:3] == '0))
    else $error("conflict index without overlap");

  a_tour_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11] |-> (st == bpc_pkg::ST_OK))
    else $error("tour_ok set on a failed box");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind box_placement_checker_core bpc_checker u_bpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
